### sv/brb_pkg.sv
// shared types and constants for the byte ring buffer with overwrite
// no dependencies
`default_nettype none

package brb_pkg;

  localparam int DEPTH_DEF  = 256;
  localparam int BURST_DEF  = 8;
  localparam int DATA_W     = 64;
  localparam int LEN_W      = 4;
  localparam int FILL_W     = 9;
  localparam int CNTR_W     = 32;
  localparam int LOG_NB_DEF = 3;
  localparam int PTR_W_DEF  = 8;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } brb_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } brb_status_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [LEN_W-1:0]  byte_length;
    logic [DATA_W-1:0] write_bytes;
  } brb_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [LEN_W-1:0]  moved_bytes;
    logic [DATA_W-1:0] read_bytes_out;
    logic [FILL_W-1:0] fill_level;
    logic [CNTR_W-1:0] writes_total;
    logic [CNTR_W-1:0] reads_total;
    logic [CNTR_W-1:0] overflows_total;
  } brb_out_t;

  typedef struct packed {
    logic              en;
    logic [LEN_W-1:0]  cnt;
    logic [DATA_W-1:0] data;
  } brb_wr_t;

endpackage

`default_nettype wire

### sv/brb_store.sv
// banked byte store: one write of up to NB consecutive bytes and one read
// of NB consecutive bytes per cycle, read data registered and put in order
// depends on brb_pkg
`default_nettype none

module brb_store #(
  parameter int PTR_W  = brb_pkg::PTR_W_DEF,
  parameter int LOG_NB = brb_pkg::LOG_NB_DEF
) (
  input  wire logic                 clk,
  input  wire brb_pkg::brb_wr_t     wr,
  input  wire logic [PTR_W-1:0]     wr_ptr,
  input  wire logic                 rd_en,
  input  wire logic [PTR_W-1:0]     rd_ptr,
  output logic [(1<<LOG_NB)-1:0][7:0] rd_lanes
);
  import brb_pkg::*;

  localparam int NB    = 1 << LOG_NB;
  localparam int ROW_W = PTR_W - LOG_NB;
  localparam int ROWS  = 1 << ROW_W;

  logic [7:0]        bank_q [NB];
  logic [LOG_NB-1:0] rd_lo_r;

  for (genvar b = 0; b < NB; b++) begin : g_bank
    logic [7:0]        mem [ROWS];
    logic [7:0]        q_r;
    logic [LOG_NB-1:0] wj;
    logic [LOG_NB-1:0] rj;
    logic [PTR_W-1:0]  wa;
    logic [PTR_W-1:0]  ra;

    assign wj = LOG_NB'(b) - wr_ptr[LOG_NB-1:0];
    assign rj = LOG_NB'(b) - rd_ptr[LOG_NB-1:0];
    assign wa = wr_ptr + PTR_W'(wj);
    assign ra = rd_ptr + PTR_W'(rj);

    always_ff @(posedge clk) begin
      if (wr.en && (LEN_W'(wj) < wr.cnt)) begin
        mem[wa[PTR_W-1:LOG_NB]] <= wr.data[8*wj +: 8];
      end
      if (rd_en) begin
        q_r <= mem[ra[PTR_W-1:LOG_NB]];
      end
    end

    assign bank_q[b] = q_r;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_lo_r <= rd_ptr[LOG_NB-1:0];
    end
  end

  // lane j holds the j-th oldest byte of the read window
  always_comb begin
    for (int j = 0; j < NB; j++) begin
      rd_lanes[j] = bank_q[rd_lo_r + LOG_NB'(j)];
    end
  end

endmodule

`default_nettype wire

### sv/byte_ring_buffer_overwrite_unit.sv
// top level of the byte ring buffer with optional overwrite of oldest data
// depends on brb_pkg and brb_store
`default_nettype none

// Byte ring buffer of DEPTH bytes (256, fixed by the package) taking write, read and
// clear transactions of up to BURST_BYTES bytes. One transaction is accepted per clock
// cycle while results are taken, and each result passes three registers (input, store
// read data, result) before it is presented. The rate is set by the banked store: bytes
// are spread over a power-of-two number of one-byte banks, each taking one write and
// one read per cycle, so a whole burst moves in one access. Pointer and fill updates
// are a short add and compare in the input stage. The store needs no clearing after
// reset.
module byte_ring_buffer_overwrite_unit #(
  parameter int BURST_BYTES = brb_pkg::BURST_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire brb_pkg::brb_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output brb_pkg::brb_out_t      out_data,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_wr_data
);
  import brb_pkg::*;

  localparam int DEPTH  = DEPTH_DEF;
  localparam int LOG_NB = (BURST_BYTES > 1) ? $clog2(BURST_BYTES) : 1;
  localparam int NB     = 1 << LOG_NB;
  localparam int PTR_A  = $clog2(DEPTH);
  localparam int PTR_W  = (PTR_A > LOG_NB) ? PTR_A : LOG_NB + 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int FX_W   = (CNT_W > FILL_W) ? CNT_W : FILL_W;
  localparam logic [LEN_W-1:0] BURST_LEN = LEN_W'(BURST_BYTES);

  // pipeline control
  logic     a_valid_r, b_valid_r, out_valid_r;
  logic     a_free, b_free, o_free, a_fire, b_fire;
  brb_in_t  a_r;
  brb_out_t b_res_r, out_data_r;
  logic     b_rd_r;

  // buffer state
  logic              ovw_r;
  logic [PTR_W-1:0]  rp_r, rp_nxt, wp_r, wp_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [CNTR_W-1:0] wr_tot_r, wr_tot_nxt, rd_tot_r, rd_tot_nxt, ovf_r, ovf_nxt;

  logic [LEN_W-1:0]  len_sat, n;
  logic [CNT_W-1:0]  len_ext, space;
  logic [SUM_W-1:0]  sum;
  logic [1:0]        st;
  logic              is_rd;
  logic [FX_W-1:0]   fill_ext;
  brb_wr_t           wr;
  logic [NB-1:0][7:0] rd_lanes;
  logic [DATA_W-1:0] rdata;

  assign o_free   = !out_valid_r || out_ready;
  assign b_free   = !b_valid_r || o_free;
  assign a_free   = !a_valid_r || b_free;
  assign a_fire   = a_valid_r && b_free;
  assign b_fire   = b_valid_r && o_free;
  assign in_ready = a_free;

  always_comb begin
    len_sat    = (a_r.byte_length > BURST_LEN) ? BURST_LEN : a_r.byte_length;
    len_ext    = CNT_W'(len_sat);
    space      = CNT_W'(DEPTH) - held_r;
    sum        = '0;
    n          = '0;
    st         = ST_OK;
    is_rd      = 1'b0;
    rp_nxt     = rp_r;
    wp_nxt     = wp_r;
    held_nxt   = held_r;
    wr_tot_nxt = wr_tot_r;
    rd_tot_nxt = rd_tot_r;
    ovf_nxt    = ovf_r;
    wr.en      = 1'b0;
    wr.data    = a_r.write_bytes;
    case (a_r.operation)
      OP_WRITE: begin
        if (len_sat != '0) begin
          n = len_sat;
          if (len_ext > space) begin
            if (ovw_r) begin
              ovf_nxt = ovf_r + 1'b1;
            end else begin
              n = LEN_W'(space);
            end
          end
          if (n == '0) begin
            st = ST_FULL;
          end else begin
            wr.en      = a_fire;
            wp_nxt     = wp_r + PTR_W'(n);
            sum        = SUM_W'(held_r) + SUM_W'(n);
            wr_tot_nxt = wr_tot_r + 1'b1;
            if (sum > SUM_W'(DEPTH)) begin
              held_nxt = CNT_W'(DEPTH);
              rp_nxt   = rp_r + PTR_W'(sum - SUM_W'(DEPTH));
            end else begin
              held_nxt = CNT_W'(sum);
            end
          end
        end
      end
      OP_READ: begin
        if (len_sat != '0) begin
          if (held_r == '0) begin
            st = ST_EMPTY;
          end else begin
            n          = (len_ext < held_r) ? len_sat : LEN_W'(held_r);
            is_rd      = 1'b1;
            rp_nxt     = rp_r + PTR_W'(n);
            held_nxt   = held_r - CNT_W'(n);
            rd_tot_nxt = rd_tot_r + 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        rp_nxt   = '0;
        wp_nxt   = '0;
        held_nxt = '0;
      end
      default: begin
      end
    endcase
    wr.cnt   = n;
    fill_ext = FX_W'(held_nxt);
  end

  brb_store #(
    .PTR_W  (PTR_W),
    .LOG_NB (LOG_NB)
  ) u_store (
    .clk      (clk),
    .wr       (wr),
    .wr_ptr   (wp_r),
    .rd_en    (a_fire),
    .rd_ptr   (rp_r),
    .rd_lanes (rd_lanes)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      ovw_r       <= 1'b0;
      rp_r        <= '0;
      wp_r        <= '0;
      held_r      <= '0;
      wr_tot_r    <= '0;
      rd_tot_r    <= '0;
      ovf_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        ovw_r <= cfg_wr_data;
      end
      if (a_free) begin
        a_valid_r <= in_valid;
      end
      if (b_free) begin
        b_valid_r <= a_valid_r;
      end
      if (o_free) begin
        out_valid_r <= b_valid_r;
      end
      if (a_fire) begin
        rp_r     <= rp_nxt;
        wp_r     <= wp_nxt;
        held_r   <= held_nxt;
        wr_tot_r <= wr_tot_nxt;
        rd_tot_r <= rd_tot_nxt;
        ovf_r    <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_free) begin
      a_r <= in_data;
    end
    if (a_fire) begin
      b_res_r.status          <= st;
      b_res_r.moved_bytes     <= n;
      b_res_r.read_bytes_out  <= '0;
      b_res_r.fill_level      <= fill_ext[FILL_W-1:0];
      b_res_r.writes_total    <= wr_tot_nxt;
      b_res_r.reads_total     <= rd_tot_nxt;
      b_res_r.overflows_total <= ovf_nxt;
      b_rd_r                  <= is_rd;
    end
    if (b_fire) begin
      out_data_r <= {b_res_r.status, b_res_r.moved_bytes, rdata, b_res_r.fill_level,
                     b_res_r.writes_total, b_res_r.reads_total, b_res_r.overflows_total};
    end
  end

  // keep only the bytes this read transaction moved
  always_comb begin
    rdata = '0;
    for (int j = 0; j < NB; j++) begin
      if (b_rd_r && (LEN_W'(j) < b_res_r.moved_bytes)) begin
        rdata[8*j +: 8] = rd_lanes[j];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_ptr_span: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r - rp_r) == PTR_W'(held_r))
    else $error("pointer distance does not match fill count");

  a_moved_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.moved_bytes <= BURST_LEN)
    else $error("moved bytes above burst size");

  a_full_nothing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == ST_FULL || out_data_r.status == ST_EMPTY))
      |-> (out_data_r.moved_bytes == '0 && out_data_r.read_bytes_out == '0))
    else $error("full or empty transaction moved data");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !a_fire |=> ($stable(held_r) && $stable(rp_r) && $stable(wp_r)))
    else $error("buffer state changed without a transaction");

endmodule

`default_nettype wire
